// ----- sv/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// prt_pkg
// Shared constants for the progress rank tracker: operation codes, fixed
// port widths and default parameter values.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int USER_W   = 10;
    localparam int PROG_W   = 10;
    localparam int BEHIND_W = 11;
    localparam int OTHERS_W = 10;

    localparam int DEF_USER_SLOTS    = 1024;
    localparam int DEF_MAX_PROGRESS  = 1023;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

endpackage

// ----- sv/prt_divider.sv -----
// ----------------------------------------------------------------------------
// prt_divider
// Restoring divider, one quotient bit per cycle: quot = (num << FRAC_W) / den,
// for num <= den and den >= 1.
// ----------------------------------------------------------------------------
module prt_divider #(
    parameter int NUM_W  = 11,
    parameter int FRAC_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [NUM_W-1:0]  den,
    output logic              done,
    output logic [FRAC_W:0]   quot
);

    localparam int CNT_W = $clog2(FRAC_W + 2);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W:0]    rem_reg;
    logic [FRAC_W:0]   quot_reg;

    logic [NUM_W:0]    den_ext;
    logic              ge;
    logic [NUM_W:0]    rem_sub;
    logic [NUM_W:0]    rem_next;

    // remainder stays below den, so the shifted value fits NUM_W+1 bits
    always_comb
    begin
        den_ext  = {1'b0, den};
        ge       = (rem_reg >= den_ext);
        rem_sub  = ge ? (rem_reg - den_ext) : rem_reg;
        rem_next = {rem_sub[NUM_W-1:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_W + 1);
                rem_reg  <= {1'b0, num};
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                quot_reg <= {quot_reg[FRAC_W-1:0], ge};
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- sv/progress_rank_tracker.sv -----
// Update: ignored if user or progress is out of range, else a read-modify-write; no result.
// Query: reads one histogram bin per cycle below the user's progress, then one divider bit
//   per cycle; an unseen or sole user skips both.
// One transaction at a time.
// After reset a clearing pass over max(USER_SLOTS, MAX_PROGRESS+1) entries zeroes
//   both stores; no input transaction is taken meanwhile.
// ----------------------------------------------------------------------------
// progress_rank_tracker
// Per-user progress store and progress histogram; answers the share of other
// active users with strictly lower progress.
// ----------------------------------------------------------------------------
module progress_rank_tracker #(
    parameter int USER_SLOTS    = prt_pkg::DEF_USER_SLOTS,
    parameter int MAX_PROGRESS  = prt_pkg::DEF_MAX_PROGRESS,
    parameter int FRACTION_BITS = prt_pkg::DEF_FRACTION_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [prt_pkg::USER_W-1:0]   user,
    input  logic [prt_pkg::PROG_W-1:0]   progress,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [FRACTION_BITS:0]       share,
    output logic [prt_pkg::BEHIND_W-1:0] behind_count,
    output logic [prt_pkg::OTHERS_W-1:0] others_count
);

    localparam int USER_W   = prt_pkg::USER_W;
    localparam int PIN_W    = prt_pkg::PROG_W;
    localparam int BEHIND_W = prt_pkg::BEHIND_W;
    localparam int OTHERS_W = prt_pkg::OTHERS_W;
    localparam int UIDX_W   = $clog2(USER_SLOTS);
    localparam int PV_W     = $clog2(MAX_PROGRESS + 1);
    localparam int HIST_N   = MAX_PROGRESS + 1;
    localparam int CNT_W    = $clog2(USER_SLOTS + 1);
    localparam int CLR_N    = (USER_SLOTS > HIST_N) ? USER_SLOTS : HIST_N;
    localparam int CLR_W    = $clog2(CLR_N);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_CHECK,
        ST_DEC_RD,
        ST_DEC_WR,
        ST_INC_RD,
        ST_INC_WR,
        ST_WALK,
        ST_DIV,
        ST_EMIT
    } state_t;

    // stores
    logic [PV_W-1:0]  up_mem   [USER_SLOTS];
    logic [CNT_W-1:0] hist_mem [HIST_N];

    state_t              state_reg;
    logic [CLR_W-1:0]    clr_reg;
    logic                op_reg;
    logic [USER_W-1:0]   user_reg;
    logic [PIN_W-1:0]    prog_reg;
    logic [CNT_W-1:0]    active_reg;
    logic [PV_W-1:0]     old_reg;
    logic [PV_W-1:0]     mine_reg;
    logic [PV_W-1:0]     v_reg;
    logic                pend_reg;
    logic [CNT_W-1:0]    acc_reg;
    logic [FRACTION_BITS:0] res_share_reg;
    logic [CNT_W-1:0]    res_behind_reg;
    logic [CNT_W-1:0]    res_others_reg;
    logic                out_valid_reg;
    logic [FRACTION_BITS:0] share_reg;
    logic [CNT_W-1:0]    behind_reg;
    logic [CNT_W-1:0]    others_reg;

    logic [PV_W-1:0]     up_q_reg;
    logic [CNT_W-1:0]    hist_q_reg;

    logic                up_we;
    logic [UIDX_W-1:0]   up_waddr;
    logic [PV_W-1:0]     up_wdata;
    logic                hist_we;
    logic [PV_W-1:0]     hist_waddr;
    logic [CNT_W-1:0]    hist_wdata;
    logic [PV_W-1:0]     hist_raddr;

    logic                user_ok;
    logic                prog_ok;
    logic [UIDX_W-1:0]   uidx;
    logic [PV_W-1:0]     pidx;
    logic [CNT_W-1:0]    others;
    logic [CNT_W-1:0]    behind_cap;
    logic                walk_done;
    logic                div_start;
    logic                div_done;
    logic [FRACTION_BITS:0] div_quot;

    always_comb
    begin
        user_ok    = (32'(user_reg) < 32'(USER_SLOTS));
        prog_ok    = (prog_reg != '0) && (32'(prog_reg) <= 32'(MAX_PROGRESS));
        uidx       = UIDX_W'(user_reg);
        pidx       = PV_W'(prog_reg);
        others     = active_reg - CNT_W'(1);
        behind_cap = (acc_reg > others) ? others : acc_reg;
        walk_done  = (v_reg >= mine_reg) && !pend_reg;
        div_start  = (state_reg == ST_WALK) && walk_done;
    end

    // write ports and histogram read address
    always_comb
    begin
        up_we      = 1'b0;
        up_waddr   = uidx;
        up_wdata   = pidx;
        hist_we    = 1'b0;
        hist_waddr = pidx;
        hist_wdata = hist_q_reg + CNT_W'(1);
        hist_raddr = v_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                up_we      = (32'(clr_reg) < 32'(USER_SLOTS));
                up_waddr   = UIDX_W'(clr_reg);
                up_wdata   = '0;
                hist_we    = (32'(clr_reg) < 32'(HIST_N));
                hist_waddr = PV_W'(clr_reg);
                hist_wdata = '0;
            end
            ST_CHECK:
            begin
                up_we = (op_reg == prt_pkg::OP_UPDATE);
            end
            ST_DEC_RD:
            begin
                hist_raddr = old_reg;
            end
            ST_DEC_WR:
            begin
                hist_we    = (hist_q_reg != '0);
                hist_waddr = old_reg;
                hist_wdata = hist_q_reg - CNT_W'(1);
            end
            ST_INC_RD:
            begin
                hist_raddr = pidx;
            end
            ST_INC_WR:
            begin
                hist_we = 1'b1;
            end
            default:
            begin
                hist_raddr = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (up_we)
        begin
            up_mem[up_waddr] <= up_wdata;
        end
        up_q_reg <= up_mem[uidx];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q_reg <= hist_mem[hist_raddr];
    end

    prt_divider #(
        .NUM_W  (CNT_W),
        .FRAC_W (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (behind_cap),
        .den   (others),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            active_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // ST_EMIT reloads the output register itself
            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + CLR_W'(1);
                    if (32'(clr_reg) == 32'(CLR_N - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= op;
                        user_reg  <= user;
                        prog_reg  <= progress;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    if (op_reg == prt_pkg::OP_UPDATE)
                    begin
                        state_reg <= (user_ok && prog_ok) ? ST_CHECK : ST_IDLE;
                    end
                    else if (!user_ok)
                    begin
                        res_share_reg  <= '0;
                        res_behind_reg <= '0;
                        res_others_reg <= '0;
                        state_reg      <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (op_reg == prt_pkg::OP_UPDATE)
                    begin
                        old_reg <= up_q_reg;
                        if (up_q_reg == '0)
                        begin
                            active_reg <= active_reg + CNT_W'(1);
                            state_reg  <= ST_INC_RD;
                        end
                        else
                        begin
                            state_reg <= ST_DEC_RD;
                        end
                    end
                    else
                    begin
                        res_behind_reg <= '0;
                        res_others_reg <= '0;
                        if (up_q_reg == '0 || active_reg == '0)
                        begin
                            res_share_reg <= '0;
                            state_reg     <= ST_EMIT;
                        end
                        else if (active_reg == CNT_W'(1))
                        begin
                            // sole active user counts as fully ahead
                            res_share_reg <= (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
                            state_reg     <= ST_EMIT;
                        end
                        else
                        begin
                            mine_reg  <= up_q_reg;
                            v_reg     <= PV_W'(1);
                            acc_reg   <= '0;
                            pend_reg  <= 1'b0;
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_DEC_RD:
                begin
                    state_reg <= ST_DEC_WR;
                end
                ST_DEC_WR:
                begin
                    state_reg <= ST_INC_RD;
                end
                ST_INC_RD:
                begin
                    state_reg <= ST_INC_WR;
                end
                ST_INC_WR:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_WALK:
                begin
                    // bin read issued this cycle lands in hist_q_reg next cycle
                    if (v_reg < mine_reg)
                    begin
                        v_reg    <= v_reg + PV_W'(1);
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg)
                    begin
                        acc_reg <= acc_reg + hist_q_reg;
                    end
                    if (walk_done)
                    begin
                        res_behind_reg <= behind_cap;
                        res_others_reg <= others;
                        state_reg      <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_share_reg <= div_quot;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        share_reg     <= res_share_reg;
                        behind_reg    <= res_behind_reg;
                        others_reg    <= res_others_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign share        = share_reg;
    assign behind_count = BEHIND_W'(behind_reg);
    assign others_count = OTHERS_W'(others_reg);

endmodule

// ----- tb/sv/tb_progress_rank_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_progress_rank_tracker
// Self-checking bench for the progress rank tracker. Drives progress updates
// and rank queries through the valid/stall handshake. A scoreboard keeps its
// own user store and histogram, works out each query's share, behind and
// others counts, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb_progress_rank_tracker;

    localparam int SLOTS      = prt_pkg::DEF_USER_SLOTS;
    localparam int MAX_PROG   = prt_pkg::DEF_MAX_PROGRESS;
    localparam int FRAC       = prt_pkg::DEF_FRACTION_BITS;
    localparam int USER_W     = prt_pkg::USER_W;
    localparam int PROG_W     = prt_pkg::PROG_W;
    localparam int BEHIND_W   = prt_pkg::BEHIND_W;
    localparam int OTHERS_W   = prt_pkg::OTHERS_W;
    localparam int SETTLE     = MAX_PROG + FRAC + 64;
    localparam int LIMIT      = 4000000;
    localparam int HOLD_LEN   = 3000;

    typedef struct packed {
        logic [FRAC:0]         share;
        logic [BEHIND_W-1:0]   behind;
        logic [OTHERS_W-1:0]   others;
    } rank_answer_t;

    class rank_scoreboard;
        logic [PROG_W-1:0] user_level [SLOTS];
        int unsigned       level_count [MAX_PROG+1];
        int unsigned       active_total;
        rank_answer_t      answers_due [$];
        int                errors;

        function new();
            foreach (user_level[i]) user_level[i] = '0;
            foreach (level_count[i]) level_count[i] = 0;
            active_total = 0;
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return answers_due.size();
        endfunction

        // Applies an accepted input transaction; a query queues its answer.
        task note_input(logic kind, logic [USER_W-1:0] who, logic [PROG_W-1:0] level);
            rank_answer_t      a;
            logic [PROG_W-1:0] mine;
            longint unsigned   below;
            longint unsigned   rest;
            if (kind == prt_pkg::OP_UPDATE)
            begin
                if (int'(who) >= SLOTS || level == 0 || int'(level) > MAX_PROG)
                    return;
                mine = user_level[who];
                if (mine == 0)
                    active_total++;
                else if (level_count[mine] > 0)
                    level_count[mine]--;
                user_level[who] = level;
                level_count[level]++;
            end
            else
            begin
                a = '0;
                mine = (int'(who) < SLOTS) ? user_level[who] : '0;
                if (mine != 0 && active_total != 0)
                begin
                    if (active_total == 1)
                    begin
                        a.share = (FRAC + 1)'(1) << FRAC;
                    end
                    else
                    begin
                        below = 0;
                        for (int v = 1; v < int'(mine); v++)
                            below += level_count[v];
                        rest = active_total - 1;
                        if (below > rest)
                            below = rest;
                        a.share  = (FRAC + 1)'((below << FRAC) / rest);
                        a.behind = BEHIND_W'(below);
                        a.others = OTHERS_W'(rest);
                    end
                end
                answers_due.push_back(a);
            end
        endtask

        task check_result(logic [FRAC:0] s, logic [BEHIND_W-1:0] b,
                          logic [OTHERS_W-1:0] c);
            rank_answer_t want;
            if (answers_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result share=%0d behind=%0d others=%0d",
                                          s, b, c));
                return;
            end
            want = answers_due.pop_front();
            if (s !== want.share)
                report_mismatch($sformatf("share %0d, expected %0d", s, want.share));
            if (b !== want.behind)
                report_mismatch($sformatf("behind_count %0d, expected %0d", b, want.behind));
            if (c !== want.others)
                report_mismatch($sformatf("others_count %0d, expected %0d", c, want.others));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                op = prt_pkg::OP_UPDATE;
    logic [USER_W-1:0]   user = '0;
    logic [PROG_W-1:0]   progress = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [FRAC:0]       share;
    logic [BEHIND_W-1:0] behind_count;
    logic [OTHERS_W-1:0] others_count;

    rank_scoreboard sb = new();

    int tx_idle_pct = 12;
    int rx_idle_pct = 65;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    progress_rank_tracker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .user         (user),
        .progress     (progress),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .share        (share),
        .behind_count (behind_count),
        .others_count (others_count)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(op, user, progress);
            if (out_valid && !out_stall)
                sb.check_result(share, behind_count, others_count);
        end
    end

    // Result side: random stall, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Offers one transaction, holds it until taken, then maybe idles.
    task automatic send_txn(input logic kind, input logic [USER_W-1:0] who,
                            input logic [PROG_W-1:0] level);
        int gap;
        in_valid <= 1'b1;
        op       <= kind;
        user     <= who;
        progress <= level;
        do @(posedge clk); while (in_stall);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly a small pool of users and low progress so queries stay short.
    task automatic send_random(input int count);
        logic              kind;
        logic [USER_W-1:0] who;
        logic [PROG_W-1:0] level;
        int                r;
        for (int i = 0; i < count; i++)
        begin
            kind = ($urandom_range(99) < 45) ? prt_pkg::OP_QUERY : prt_pkg::OP_UPDATE;
            who  = ($urandom_range(99) < 70) ? USER_W'($urandom_range(63))
                                             : USER_W'($urandom_range(SLOTS-1));
            r    = $urandom_range(99);
            if (kind == prt_pkg::OP_QUERY)
                level = PROG_W'($urandom_range(1023));
            else if (r < 6)
                level = '0;
            else if (r < 80)
                level = PROG_W'($urandom_range(63, 1));
            else
                level = PROG_W'($urandom_range(MAX_PROG, 1));
            send_txn(kind, who, level);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unseen, sole user, ties, extremes, move down, ignored update
        send_txn(prt_pkg::OP_QUERY,  10'd0,    10'd0);
        send_txn(prt_pkg::OP_QUERY,  10'd1023, 10'd1023);
        send_txn(prt_pkg::OP_UPDATE, 10'd0,    10'd1023);
        send_txn(prt_pkg::OP_QUERY,  10'd0,    10'd0);
        send_txn(prt_pkg::OP_UPDATE, 10'd5,    10'd0);
        send_txn(prt_pkg::OP_QUERY,  10'd5,    10'd0);
        send_txn(prt_pkg::OP_UPDATE, 10'd1023, 10'd1);
        send_txn(prt_pkg::OP_QUERY,  10'd0,    10'd0);
        send_txn(prt_pkg::OP_QUERY,  10'd1023, 10'd0);
        send_txn(prt_pkg::OP_UPDATE, 10'd512,  10'd512);
        send_txn(prt_pkg::OP_QUERY,  10'd512,  10'd0);
        send_txn(prt_pkg::OP_UPDATE, 10'd0,    10'd1);
        send_txn(prt_pkg::OP_QUERY,  10'd0,    10'd0);
        send_txn(prt_pkg::OP_QUERY,  10'd512,  10'd0);
        send_txn(prt_pkg::OP_UPDATE, 10'd341,  10'd682);
        send_txn(prt_pkg::OP_UPDATE, 10'd682,  10'd341);
        send_txn(prt_pkg::OP_QUERY,  10'd341,  10'd0);
        send_txn(prt_pkg::OP_QUERY,  10'd682,  10'd1023);
        send_txn(prt_pkg::OP_UPDATE, 10'd512,  10'd512);
        send_txn(prt_pkg::OP_QUERY,  10'd512,  10'd1023);
        send_txn(prt_pkg::OP_UPDATE, 10'd1023, 10'd1023);
        send_txn(prt_pkg::OP_QUERY,  10'd1023, 10'd341);

        send_random(170);

        tx_idle_pct = 65;
        rx_idle_pct = 12;
        send_random(170);

        // no idling; long result hold-off so the block backs up its input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        send_random(180);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
